// File: sv/cht_pkg.sv
// Package for the chained hash table: widths, status and command codes.
// No dependencies.
package cht_pkg;
  localparam int unsigned MAX_BUCKETS_DEF = 256;
  localparam int unsigned POOL_NODES_DEF  = 256;
  localparam int unsigned KEY_WIDTH_DEF   = 32;
  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned BCNT_W   = 9;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned VALUE_W  = 32;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUP       = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  // controller -> datapath commands
  typedef struct packed {
    logic load;       // capture the input beat, start modulo
    logic mod_step;   // one restoring-divide step
    logic head_rd;    // read bucket head
    logic node_rd;    // read current node
    logic advance;    // prev <= cur, cur <= next
    logic do_insert;
    logic do_remove;
    logic do_lookup;  // latch value
    logic set_dup;
    logic set_full;
    logic set_nf;
  } cht_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic mod_done;
    logic cur_nil;
    logic key_match;
    logic steps_done;
    logic pool_empty;
    logic [CMD_W-1:0] cmd;
  } cht_sts_t;
endpackage

// File: sv/cht_if.sv
// Valid/ready channel interfaces for the chained hash table.
// Depends on cht_pkg.
interface cht_in_if import cht_pkg::*; #(
  parameter int unsigned KW = KEY_WIDTH_DEF,
  parameter int unsigned VW = VALUE_WIDTH_DEF
);
  logic valid;
  logic ready;
  logic [CMD_W-1:0] command;
  logic [KW-1:0] key;
  logic [VW-1:0] value_in;
  modport source (output valid, command, key, value_in, input ready);
  modport sink (input valid, command, key, value_in, output ready);
endinterface

interface cht_out_if import cht_pkg::*; #(
  parameter int unsigned VW = VALUE_WIDTH_DEF
);
  logic valid;
  logic ready;
  logic [STATUS_W-1:0] status;
  logic [VW-1:0] value_out;
  modport source (output valid, status, value_out, input ready);
  modport sink (input valid, status, value_out, output ready);
endinterface

interface cht_cfg_if import cht_pkg::*;;
  logic valid;
  logic ready;
  logic [BCNT_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: sv/cht_ctrl.sv
// Controller FSM of the chained hash table: sequences modulo, chain walk
// and update. Depends on cht_pkg.
module cht_ctrl import cht_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     res_valid,
  input  logic     res_ready,
  input  cht_sts_t sts,
  output cht_cmd_t cmd
);
  typedef enum logic [2:0] {S_IDLE, S_MOD, S_HEAD, S_NODE, S_CHECK, S_DONE} state_t;
  state_t state_r, state_nxt;
  logic   res_valid_r, res_valid_nxt;

  assign in_ready  = (state_r == S_IDLE) && !res_valid_r;
  assign res_valid = res_valid_r;

  always_comb begin
    state_nxt     = state_r;
    res_valid_nxt = res_valid_r && !res_ready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load  = 1'b1;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        if (sts.mod_done) begin
          cmd.head_rd = 1'b1;
          state_nxt   = S_HEAD;
        end else begin
          cmd.mod_step = 1'b1;
        end
      end
      S_HEAD: begin
        cmd.node_rd = 1'b1;
        state_nxt   = S_NODE;
      end
      S_NODE: state_nxt = S_CHECK;
      S_CHECK: begin
        state_nxt = S_DONE;
        if (sts.cur_nil || sts.steps_done) begin
          if (sts.cmd == CMD_INSERT) begin
            if (sts.pool_empty) cmd.set_full = 1'b1;
            else cmd.do_insert = 1'b1;
          end else begin
            cmd.set_nf = 1'b1;
          end
        end else if (sts.key_match) begin
          case (sts.cmd)
            CMD_INSERT: cmd.set_dup = 1'b1;
            CMD_REMOVE: cmd.do_remove = 1'b1;
            CMD_LOOKUP: cmd.do_lookup = 1'b1;
            default:    cmd.set_nf = 1'b1;
          endcase
        end else begin
          cmd.advance = 1'b1;
          cmd.node_rd = 1'b1;
          state_nxt   = S_NODE;
        end
      end
      S_DONE: begin
        res_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end
endmodule

// File: sv/cht_dp.sv
// Datapath of the chained hash table: bit-serial modulo, bucket heads,
// node memories and free stack. Depends on cht_pkg.
module cht_dp import cht_pkg::*; #(
  parameter int unsigned MAX_BUCKETS = MAX_BUCKETS_DEF,
  parameter int unsigned POOL_NODES  = POOL_NODES_DEF,
  parameter int unsigned KEY_WIDTH   = KEY_WIDTH_DEF,
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cht_cmd_t               cmd,
  output cht_sts_t               sts,
  input  logic [CMD_W-1:0]       in_command,
  input  logic [KEY_WIDTH-1:0]   in_key,
  input  logic [VALUE_WIDTH-1:0] in_value,
  input  logic                   cfg_we,
  input  logic [BCNT_W-1:0]      cfg_data,
  output logic [STATUS_W-1:0]    res_status,
  output logic [VALUE_WIDTH-1:0] res_value
);
  localparam int unsigned BW  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int unsigned NW  = $clog2(POOL_NODES + 1);   // node index incl. nil
  localparam int unsigned IW  = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam int unsigned DW  = $clog2(MAX_BUCKETS + 1);  // divisor width
  localparam int unsigned KCW = $clog2(KEY_WIDTH + 1);
  localparam logic [NW-1:0] NIL = NW'(POOL_NODES);

  logic [BCNT_W-1:0]      bcnt_r;
  logic [DW-1:0]          div_r;
  logic [CMD_W-1:0]       cmd_r;
  logic [KEY_WIDTH-1:0]   key_r, kshift_r;
  logic [VALUE_WIDTH-1:0] val_r;
  logic [DW:0]            rem_r;
  logic [KCW-1:0]         kcnt_r;
  logic [NW-1:0]          cur_r, prev_r, next_r, head_q_r;
  logic [NW:0]            steps_r;
  logic [KEY_WIDTH-1:0]   nkey_q_r;
  logic [VALUE_WIDTH-1:0] nval_q_r;
  logic [NW-1:0]          free_cnt_r;
  logic [NW-1:0]          low_r;     // lowest free count so far
  logic [IW-1:0]          pop_q_r;
  logic [STATUS_W-1:0]    status_r;
  logic [VALUE_WIDTH-1:0] vout_r;
  logic [MAX_BUCKETS-1:0] hvalid_r;

  logic [NW-1:0]          head_mem [MAX_BUCKETS];
  logic [KEY_WIDTH-1:0]   key_mem  [POOL_NODES];
  logic [VALUE_WIDTH-1:0] val_mem  [POOL_NODES];
  logic [NW-1:0]          next_mem [POOL_NODES];
  logic [IW-1:0]          free_mem [POOL_NODES];

  logic [DW:0]     rem_sh, rem_sub;
  logic [BW-1:0]   bkt;
  logic [NW-1:0]   head_cur;
  logic [IW-1:0]   fidx, pop_idx, pidx, cidx;
  logic [NW-1:0]   pop_node;
  logic [DW-1:0]   div_c;

  always_comb begin
    if (bcnt_r == '0) div_c = DW'(1);
    else if ({{32{1'b0}}, bcnt_r} > 41'(MAX_BUCKETS)) div_c = DW'(MAX_BUCKETS);
    else div_c = DW'(bcnt_r);
  end

  assign rem_sh  = {rem_r[DW-1:0], kshift_r[KEY_WIDTH-1]};
  assign rem_sub = rem_sh - {1'b0, div_r};
  assign bkt     = BW'(rem_r);
  assign head_cur = hvalid_r[bkt] ? head_q_r : NIL;
  assign fidx    = IW'(free_cnt_r - NW'(1));
  // entries below the low-water mark were never pushed: they hold their index
  assign pop_idx = (free_cnt_r == low_r) ? fidx : pop_q_r;
  assign pop_node = NW'(pop_idx);
  assign pidx    = IW'(prev_r);
  assign cidx    = IW'(cur_r);

  assign sts.mod_done   = (kcnt_r == '0);
  assign sts.cur_nil    = (cur_r >= NIL);
  assign sts.key_match  = (nkey_q_r == key_r);
  assign sts.steps_done = (steps_r >= (NW+1)'(POOL_NODES));
  assign sts.pool_empty = (free_cnt_r == '0);
  assign sts.cmd        = cmd_r;

  assign res_status = status_r;
  assign res_value  = vout_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bcnt_r     <= BCNT_W'(MAX_BUCKETS);
      free_cnt_r <= NW'(POOL_NODES);
      low_r      <= NW'(POOL_NODES);
      hvalid_r   <= '0;
      kcnt_r     <= '0;
    end else begin
      if (cfg_we) bcnt_r <= cfg_data;
      if (cmd.load) begin
        cmd_r    <= in_command;
        key_r    <= in_key;
        kshift_r <= in_key;
        val_r    <= in_value;
        div_r    <= div_c;
        rem_r    <= '0;
        kcnt_r   <= KCW'(KEY_WIDTH);
        steps_r  <= '0;
        status_r <= ST_NOT_FOUND;
        vout_r   <= '0;
      end
      if (cmd.mod_step) begin
        rem_r    <= rem_sub[DW] ? rem_sh : rem_sub;
        kshift_r <= kshift_r << 1;
        kcnt_r   <= kcnt_r - KCW'(1);
      end
      if (cmd.head_rd) head_q_r <= head_mem[bkt];
      if (cmd.node_rd) begin
        if (cmd.advance) begin
          prev_r  <= cur_r;
          cur_r   <= next_r;
          steps_r <= steps_r + (NW+1)'(1);
        end else begin
          prev_r <= NIL;
          cur_r  <= head_cur;
        end
      end
      if (cmd.set_dup)  status_r <= ST_DUP;
      if (cmd.set_full) status_r <= ST_FULL;
      if (cmd.set_nf)   status_r <= ST_NOT_FOUND;
      if (cmd.do_lookup) begin
        status_r <= ST_OK;
        vout_r   <= nval_q_r;
      end
      if (cmd.do_insert) begin
        status_r        <= ST_OK;
        free_cnt_r      <= free_cnt_r - NW'(1);
        hvalid_r[bkt]   <= 1'b1;
        if (free_cnt_r == low_r) low_r <= free_cnt_r - NW'(1);
      end
      if (cmd.do_remove) begin
        status_r <= ST_OK;
        if (prev_r >= NIL) hvalid_r[bkt] <= 1'b1;
        if (free_cnt_r < NW'(POOL_NODES)) free_cnt_r <= free_cnt_r + NW'(1);
      end
    end
  end

  // node memories, read of current node registered
  always_ff @(posedge clk) begin
    if (cmd.head_rd) pop_q_r <= free_mem[fidx];
    if (cmd.node_rd) begin
      if (cmd.advance) begin
        nkey_q_r <= key_mem[IW'(next_r)];
        nval_q_r <= val_mem[IW'(next_r)];
        next_r   <= next_mem[IW'(next_r)];
      end else begin
        nkey_q_r <= key_mem[IW'(head_cur)];
        nval_q_r <= val_mem[IW'(head_cur)];
        next_r   <= next_mem[IW'(head_cur)];
      end
    end
    if (cmd.do_insert) begin
      key_mem[pop_idx]  <= key_r;
      val_mem[pop_idx]  <= val_r;
      next_mem[pop_idx] <= head_cur;
      head_mem[bkt]     <= pop_node;
    end
    if (cmd.do_remove) begin
      if (prev_r >= NIL) head_mem[bkt] <= next_r;
      else next_mem[pidx] <= next_r;
      if (free_cnt_r < NW'(POOL_NODES)) free_mem[IW'(free_cnt_r)] <= cidx;
    end
  end
endmodule

// File: sv/chained_hash_table.sv
// Top level of the chained hash table: controller, datapath, output stage.
// Depends on cht_pkg, cht_if, cht_ctrl and cht_dp.
//
//  channel | dir | payload
//  in      | in  | command, key, value_in
//  out     | out | status, value_out
//  cfg     | in  | data (bucket_count)
//
// Per item: accept, then KEY_WIDTH modulo steps (one bit each), a head read,
// then a node read and a check per chain node checked, the end of the chain
// counting as one node, then the result; the node memory read port sets the
// walk. One item in flight; next beat taken once the result is taken.
// Synchronous reset, no clearing pass: heads use valid bits, the free stack a
// low-water mark.
module chained_hash_table import cht_pkg::*; #(
  parameter int unsigned MAX_BUCKETS = MAX_BUCKETS_DEF,
  parameter int unsigned POOL_NODES  = POOL_NODES_DEF,
  parameter int unsigned KEY_WIDTH   = KEY_WIDTH_DEF,
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input logic clk,
  input logic rst_n,
  cht_in_if.sink    in_ch,
  cht_out_if.source out_ch,
  cht_cfg_if.sink   cfg_ch
);
  cht_cmd_t cmd;
  cht_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  cht_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .res_valid(out_ch.valid), .res_ready(out_ch.ready),
    .sts, .cmd
  );

  cht_dp #(
    .MAX_BUCKETS(MAX_BUCKETS), .POOL_NODES(POOL_NODES),
    .KEY_WIDTH(KEY_WIDTH), .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_command(in_ch.command), .in_key(in_ch.key), .in_value(in_ch.value_in),
    .cfg_we(cfg_ch.valid), .cfg_data(cfg_ch.data),
    .res_status(out_ch.status), .res_value(out_ch.value_out)
  );

`ifndef SYNTHESIS
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready) else $error("input taken while result pending");
  a_result_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !out_ch.valid) else $error("early result");
  a_nf_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status != ST_OK) |-> (out_ch.value_out == '0))
    else $error("nonzero value on failure");
`endif
endmodule
